// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on i_clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: design/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// shared constants, codes and payload types of the chunk allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bca_pkg;

    localparam int NUM_CHUNKS       = 256;
    localparam int CHUNK_SHIFT_BITS = 22;
    localparam int ADDR_BITS        = 32;

    // used map is stored as rows of ROW_W bits
    localparam int ROW_W     = 16;
    localparam int BIT_AW    = $clog2(ROW_W);
    localparam int NUM_ROWS  = (NUM_CHUNKS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int IDX_W     = ROW_AW + BIT_AW;
    localparam int LAST_BITS = NUM_CHUNKS - (NUM_ROWS - 1) * ROW_W;

    localparam logic [63:0] ADDR_MASK =
        (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);

    // request types
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_RESP  = 2'd2;

    // result kinds
    localparam logic KIND_CTRL  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // control request operations
    localparam logic CTRL_OP_ALLOC = 1'b0;
    localparam logic CTRL_OP_FREE  = 1'b1;

    // reply status
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    // partner status
    localparam logic PSTAT_OK = 1'b0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] owner_pid;
        logic        access_rw;
        logic [31:0] free_addr;
        logic        partner_status;
    } t_req;

    typedef struct packed {
        logic        out_kind;
        logic        ctrl_op;
        logic [7:0]  ctrl_index;
        logic [15:0] ctrl_pid;
        logic        ctrl_rw;
        logic [31:0] reply_addr;
        logic [1:0]  reply_status;
    } t_rsp;

    typedef struct packed {
        logic              rd_en;
        logic [ROW_AW-1:0] rd_row;
        logic              wr_en;
        logic [ROW_AW-1:0] wr_row;
        logic [ROW_W-1:0]  wdata;
    } t_map_cmd;

    typedef struct packed {
        logic              any_free;
        logic [ROW_AW-1:0] free_row;
    } t_map_stat;

endpackage

`default_nettype wire

// File: design/bca_if.sv
// ----------------------------------------------------------------------------
// bca_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface bca_req_if
    import bca_pkg::*;
();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bca_rsp_if
    import bca_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: design/bca_map.sv
// ----------------------------------------------------------------------------
// bca_map
// used-bit map memory in rows, with row valid and row full flags
// ----------------------------------------------------------------------------
`default_nettype none

module bca_map
    import bca_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_map_cmd         i_cmd,
    output logic [ROW_W-1:0]      o_rd_data,
    output t_map_stat             o_stat
);

    logic [ROW_W-1:0]  r_mem [NUM_ROWS];
    logic [ROW_W-1:0]  r_rd_data;
    logic              r_rd_valid;
    logic [ROW_AW-1:0] r_rd_row;
    logic [NUM_ROWS-1:0] r_valid;
    logic [NUM_ROWS-1:0] r_full;

    // bits past the last chunk read as used
    function automatic logic [ROW_W-1:0] pad_mask(input logic [ROW_AW-1:0] row);
        logic [ROW_W-1:0] m;
        m = '0;
        for (int j = 0; j < ROW_W; j++) begin
            if ((32'(row) == NUM_ROWS - 1) && (j >= LAST_BITS)) begin
                m[j] = 1'b1;
            end
        end
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_row] <= i_cmd.wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_row];
            r_rd_row  <= i_cmd.rd_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_full     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_valid[i_cmd.wr_row] <= 1'b1;
                r_full[i_cmd.wr_row]  <= &(i_cmd.wdata | pad_mask(i_cmd.wr_row));
            end
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[i_cmd.rd_row];
            end
        end
    end

    assign o_rd_data = (r_rd_valid ? r_rd_data : '0) | pad_mask(r_rd_row);

    // lowest row with a free chunk
    always_comb begin
        o_stat.any_free = ~&r_full;
        o_stat.free_row = '0;
        for (int k = NUM_ROWS - 1; k >= 0; k--) begin
            if (!r_full[k]) begin
                o_stat.free_row = ROW_AW'(k);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/bitmap_chunk_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_chunk_allocator
// first-fit chunk allocator with a partner round trip per request
// ----------------------------------------------------------------------------
// Takes one request at a time and gives at most one result for it. An
// allocate passes accept with row read, bit pick and write-back, and result
// load; a free inside the map passes accept with row read, bit test and
// result load. A partner response goes from accept to result load, with a
// bit clear between when a successful free clears its bit. A busy reply, an
// allocate with the map full and a free beyond the map go from accept to
// result load. A stray partner response or an unknown request type gives no
// result. The result load also waits through every cycle in which the
// previous result still sits in the output register with ready low. The used
// map lives in a memory of 16-bit rows with a registered read; per-row full
// flags pick the first row with room, so no scan over rows is needed. Per-row
// valid flags make the whole map read as free after reset with no clearing
// pass. While a partner answer is pending, allocate and free requests get busy.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bitmap_chunk_allocator
    import bca_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bca_req_if.sink    i_req,
    bca_rsp_if.source  o_rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_REL   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    logic [2:0]       r_state,    n_state;
    logic [1:0]       r_pend_op,  n_pend_op;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0] r_idx,      n_idx;
    logic [15:0]      r_pid,      n_pid;
    logic             r_rw,       n_rw;
    t_rsp             r_res,      n_res;
    t_rsp             r_out;
    logic             r_out_valid;

    t_map_cmd         map_cmd;
    t_map_stat        map_stat;
    logic [ROW_W-1:0] w_rd_data;

    logic [31:0]       w_free_idx;
    logic              w_in_range;
    logic [63:0]       w_addr_full;
    logic [BIT_AW-1:0] w_zero_bit;
    logic              w_load;

    bca_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (map_cmd),
        .o_rd_data (w_rd_data),
        .o_stat    (map_stat)
    );

    function automatic t_rsp mk_reply(input logic [1:0] status, input logic [31:0] addr);
        t_rsp r;
        r              = '0;
        r.out_kind     = KIND_REPLY;
        r.reply_addr   = addr;
        r.reply_status = status;
        return r;
    endfunction

    function automatic t_rsp mk_ctrl(input logic op, input logic [IDX_W-1:0] idx,
                                     input logic [15:0] pid, input logic rw);
        t_rsp r;
        logic [IDX_W+7:0] e;
        e            = (IDX_W + 8)'(idx);
        r            = '0;
        r.out_kind   = KIND_CTRL;
        r.ctrl_op    = op;
        r.ctrl_index = e[7:0];
        r.ctrl_pid   = pid;
        r.ctrl_rw    = rw;
        return r;
    endfunction

    assign w_free_idx  = i_req.payload.free_addr >> CHUNK_SHIFT_BITS;
    assign w_in_range  = w_free_idx < 32'(NUM_CHUNKS);
    assign w_addr_full = (64'(r_pend_idx) << CHUNK_SHIFT_BITS) & ADDR_MASK;

    // lowest clear bit of the row just read
    always_comb begin
        w_zero_bit = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (!w_rd_data[j]) begin
                w_zero_bit = BIT_AW'(j);
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_load      = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state    = r_state;
        n_pend_op  = r_pend_op;
        n_pend_idx = r_pend_idx;
        n_idx      = r_idx;
        n_pid      = r_pid;
        n_rw       = r_rw;
        n_res      = r_res;
        map_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.payload.req_type)
                        REQ_ALLOC: begin
                            if (r_pend_op != OP_NONE) begin
                                n_res   = mk_reply(ST_BUSY, '0);
                                n_state = S_EMIT;
                            end else if (!map_stat.any_free) begin
                                n_res   = mk_reply(ST_FAIL, '0);
                                n_state = S_EMIT;
                            end else begin
                                map_cmd.rd_en  = 1'b1;
                                map_cmd.rd_row = map_stat.free_row;
                                n_idx          = {map_stat.free_row, BIT_AW'(0)};
                                n_pid          = i_req.payload.owner_pid;
                                n_rw           = i_req.payload.access_rw;
                                n_state        = S_ALLOC;
                            end
                        end
                        REQ_FREE: begin
                            if (r_pend_op != OP_NONE) begin
                                n_res   = mk_reply(ST_BUSY, '0);
                                n_state = S_EMIT;
                            end else if (!w_in_range) begin
                                n_res   = mk_reply(ST_FAIL, '0);
                                n_state = S_EMIT;
                            end else begin
                                map_cmd.rd_en  = 1'b1;
                                map_cmd.rd_row = w_free_idx[IDX_W-1:BIT_AW];
                                n_idx          = w_free_idx[IDX_W-1:0];
                                n_pid          = i_req.payload.owner_pid;
                                n_rw           = i_req.payload.access_rw;
                                n_state        = S_FREE;
                            end
                        end
                        REQ_RESP: begin
                            case (r_pend_op)
                                OP_ALLOC: begin
                                    n_pend_op = OP_NONE;
                                    if (i_req.payload.partner_status == PSTAT_OK) begin
                                        n_res = mk_reply(ST_OK, w_addr_full[31:0]);
                                    end else begin
                                        n_res = mk_reply(ST_FAIL, '0);
                                    end
                                    n_state = S_EMIT;
                                end
                                OP_FREE: begin
                                    if (i_req.payload.partner_status == PSTAT_OK) begin
                                        map_cmd.rd_en  = 1'b1;
                                        map_cmd.rd_row = r_pend_idx[IDX_W-1:BIT_AW];
                                        n_state        = S_REL;
                                    end else begin
                                        n_pend_op = OP_NONE;
                                        n_res     = mk_reply(ST_FAIL, '0);
                                        n_state   = S_EMIT;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                map_cmd.wr_en  = 1'b1;
                map_cmd.wr_row = r_idx[IDX_W-1:BIT_AW];
                map_cmd.wdata  = w_rd_data | (ROW_W'(1) << w_zero_bit);
                n_pend_op      = OP_ALLOC;
                n_pend_idx     = {r_idx[IDX_W-1:BIT_AW], w_zero_bit};
                n_res          = mk_ctrl(CTRL_OP_ALLOC, {r_idx[IDX_W-1:BIT_AW], w_zero_bit},
                                         r_pid, r_rw);
                n_state        = S_EMIT;
            end
            S_FREE: begin
                if (w_rd_data[r_idx[BIT_AW-1:0]]) begin
                    n_pend_op  = OP_FREE;
                    n_pend_idx = r_idx;
                    n_res      = mk_ctrl(CTRL_OP_FREE, r_idx, r_pid, r_rw);
                end else begin
                    n_res = mk_reply(ST_FAIL, '0);
                end
                n_state = S_EMIT;
            end
            S_REL: begin
                map_cmd.wr_en  = 1'b1;
                map_cmd.wr_row = r_pend_idx[IDX_W-1:BIT_AW];
                map_cmd.wdata  = w_rd_data & ~(ROW_W'(1) << r_pend_idx[BIT_AW-1:0]);
                n_pend_op      = OP_NONE;
                n_res          = mk_reply(ST_OK, '0);
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_op   <= OP_NONE;
            r_pend_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_op  <= n_pend_op;
            r_pend_idx <= n_pend_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pid <= n_pid;
        r_rw  <= n_rw;
        r_res <= n_res;
        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    `ASSERT_IMPLIES(a_alloc_row_has_room, r_state == S_ALLOC, w_rd_data != {ROW_W{1'b1}}, "allocate read a full row")
    `ASSERT_IMPLIES(a_release_bit_set, r_state == S_REL, w_rd_data[r_pend_idx[BIT_AW-1:0]], "released chunk not marked used")
    `ASSERT_NEXT(a_emit_loads_output, w_load, r_out_valid, "result not presented after load")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// randomized check of the first-fit chunk allocator
// ----------------------------------------------------------------------------
// Drives allocate, free and partner response requests with random gaps and
// random result stalls. The allocator's behavior is tracked next to the block:
// used-chunk map, pending partner operation and its chunk. Every accepted
// request that must cause a result queues it, and each result transfer is
// checked field by field against the oldest queued one. A short directed
// pass hits the corner cases. The random pass first weights requests toward
// allocations to fill the map, then toward frees to drain it again.
// ----------------------------------------------------------------------------

module tb_top
    import bca_pkg::*;
;

    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam logic [31:0] LOW_MASK   = (32'd1 << CHUNK_SHIFT_BITS) - 32'd1;

    class chunk_map_tracker;
        typedef enum logic [1:0] {PEND_NONE, PEND_ALLOC, PEND_FREE} t_pend;

        bit [NUM_CHUNKS-1:0] used;
        t_pend               pend;
        int unsigned         pend_idx;
        t_rsp                due_results[$];
        int                  errors;

        function new();
            used     = '0;
            pend     = PEND_NONE;
            pend_idx = 0;
            errors   = 0;
        endfunction

        function bit partner_busy();
            return pend != PEND_NONE;
        endfunction

        function int pick_used();
            int start;
            int idx;
            start = $urandom_range(NUM_CHUNKS - 1);
            for (int k = 0; k < NUM_CHUNKS; k++) begin
                idx = (start + k) % NUM_CHUNKS;
                if (used[idx])
                    return idx;
            end
            return -1;
        endfunction

        function t_rsp reply(logic [1:0] st, logic [31:0] addr);
            t_rsp r;
            r              = '0;
            r.out_kind     = KIND_REPLY;
            r.reply_addr   = addr;
            r.reply_status = st;
            return r;
        endfunction

        function t_rsp ctrl(logic op, int unsigned idx, t_req q);
            t_rsp r;
            r            = '0;
            r.out_kind   = KIND_CTRL;
            r.ctrl_op    = op;
            r.ctrl_index = idx[7:0];
            r.ctrl_pid   = q.owner_pid;
            r.ctrl_rw    = q.access_rw;
            return r;
        endfunction

        function logic [31:0] chunk_addr(int unsigned idx);
            logic [63:0] a;
            a = (64'(idx) << CHUNK_SHIFT_BITS) & ADDR_MASK;
            return a[31:0];
        endfunction

        function void note_request(t_req q);
            t_rsp        r;
            bit          has;
            bit          found;
            logic [31:0] fidx;
            has = 1'b1;
            if ((q.req_type == REQ_ALLOC || q.req_type == REQ_FREE) && partner_busy()) begin
                r = reply(ST_BUSY, '0);
            end else if (q.req_type == REQ_ALLOC) begin
                r     = reply(ST_FAIL, '0);
                found = 1'b0;
                for (int k = 0; k < NUM_CHUNKS && !found; k++) begin
                    if (!used[k]) begin
                        used[k]  = 1'b1;
                        pend     = PEND_ALLOC;
                        pend_idx = k;
                        r        = ctrl(CTRL_OP_ALLOC, k, q);
                        found    = 1'b1;
                    end
                end
            end else if (q.req_type == REQ_FREE) begin
                fidx = q.free_addr >> CHUNK_SHIFT_BITS;
                if (fidx >= NUM_CHUNKS || !used[fidx]) begin
                    r = reply(ST_FAIL, '0);
                end else begin
                    pend     = PEND_FREE;
                    pend_idx = fidx;
                    r        = ctrl(CTRL_OP_FREE, fidx, q);
                end
            end else if (q.req_type == REQ_RESP && partner_busy()) begin
                if (q.partner_status != PSTAT_OK)
                    r = reply(ST_FAIL, '0);
                else if (pend == PEND_ALLOC)
                    r = reply(ST_OK, chunk_addr(pend_idx));
                else begin
                    used[pend_idx] = 1'b0;
                    r = reply(ST_OK, '0);
                end
                pend = PEND_NONE;
            end else begin
                has = 1'b0;
            end
            if (has)
                due_results.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            field_check("out_kind",     32'(want.out_kind),     32'(got.out_kind));
            field_check("ctrl_op",      32'(want.ctrl_op),      32'(got.ctrl_op));
            field_check("ctrl_index",   32'(want.ctrl_index),   32'(got.ctrl_index));
            field_check("ctrl_pid",     32'(want.ctrl_pid),     32'(got.ctrl_pid));
            field_check("ctrl_rw",      32'(want.ctrl_rw),      32'(got.ctrl_rw));
            field_check("reply_addr",   want.reply_addr,        got.reply_addr);
            field_check("reply_status", 32'(want.reply_status), 32'(got.reply_status));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bca_req_if req_if ();
    bca_rsp_if rsp_if ();

    chunk_map_tracker sb;

    int rdy_hold;
    int rdy_roll;

    bitmap_chunk_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side stalls, with stretches of steady ready
    initial rdy_hold = 0;
    always @(negedge i_clk) begin
        if (rdy_hold > 0) begin
            rdy_hold--;
        end else begin
            rdy_roll = $urandom_range(99);
            if (rdy_roll < 50) begin
                rsp_if.ready <= 1'b1;
                rdy_hold = $urandom_range(24, 1);
            end else if (rdy_roll < 85) begin
                rsp_if.ready <= 1'b0;
                rdy_hold = $urandom_range(3, 1);
            end else begin
                rsp_if.ready <= 1'b0;
                rdy_hold = $urandom_range(40, 6);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.payload);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.payload);
        end
    end

    function int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 6);
    endfunction

    function t_req mk(logic [1:0] t, logic [15:0] pid, logic rw, logic [31:0] a, logic ps);
        t_req q;
        q.req_type       = t;
        q.owner_pid      = pid;
        q.access_rw      = rw;
        q.free_addr      = a;
        q.partner_status = ps;
        return q;
    endfunction

    task send(t_req q);
        int gap;
        @(negedge i_clk);
        req_if.valid   <= 1'b1;
        req_if.payload <= q;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task run_directed();
        logic [31:0] c1;
        c1 = 32'd1 << CHUNK_SHIFT_BITS;
        send(mk(REQ_RESP,   16'h1234, 1'b1, 32'h0,        PSTAT_OK));
        send(mk(REQ_UNUSED, 16'hFFFF, 1'b1, 32'hFFFFFFFF, ~PSTAT_OK));
        send(mk(REQ_FREE,   16'h0000, 1'b0, 32'h0,        PSTAT_OK));
        send(mk(REQ_FREE,   16'hFFFF, 1'b1, 32'hFFFFFFFF, ~PSTAT_OK));
        send(mk(REQ_FREE,   16'h0000, 1'b1, 32'(NUM_CHUNKS) << CHUNK_SHIFT_BITS, PSTAT_OK));
        send(mk(REQ_ALLOC,  16'hFFFF, 1'b1, 32'h0,        PSTAT_OK));
        send(mk(REQ_ALLOC,  16'h0000, 1'b0, 32'h0,        PSTAT_OK));
        send(mk(REQ_FREE,   16'h0000, 1'b0, 32'h0,        PSTAT_OK));
        send(mk(REQ_UNUSED, 16'h0000, 1'b0, 32'h0,        PSTAT_OK));
        send(mk(REQ_RESP,   16'hFFFF, 1'b1, 32'hFFFFFFFF, PSTAT_OK));
        send(mk(REQ_ALLOC,  16'h8001, 1'b0, 32'hFFFFFFFF, PSTAT_OK));
        send(mk(REQ_RESP,   16'h0000, 1'b0, 32'h0,        ~PSTAT_OK));
        send(mk(REQ_ALLOC,  16'h00FF, 1'b1, 32'h0,        ~PSTAT_OK));
        send(mk(REQ_RESP,   16'h0000, 1'b0, 32'h0,        PSTAT_OK));
        send(mk(REQ_FREE,   16'hA5A5, 1'b1, c1 | LOW_MASK, PSTAT_OK));
        send(mk(REQ_RESP,   16'h0000, 1'b0, 32'h0,        ~PSTAT_OK));
        send(mk(REQ_FREE,   16'h5A5A, 1'b0, c1,           ~PSTAT_OK));
        send(mk(REQ_RESP,   16'h0000, 1'b1, 32'h0,        PSTAT_OK));
        send(mk(REQ_FREE,   16'h0001, 1'b0, c1,           PSTAT_OK));
        send(mk(REQ_FREE,   16'h0002, 1'b1,
                32'(NUM_CHUNKS - 1) << CHUNK_SHIFT_BITS, PSTAT_OK));
        send(mk(REQ_RESP,   16'h0003, 1'b0, 32'h0,        ~PSTAT_OK));
    endtask

    task run_random(int target);
        t_req q;
        int   counted;
        int   roll;
        int   idx;
        int   alloc_pct;
        int   free_pct;
        bit   filling;
        counted = 0;
        while (counted < target) begin
            q.req_type       = REQ_ALLOC;
            q.owner_pid      = 16'($urandom);
            q.access_rw      = 1'($urandom);
            q.free_addr      = $urandom;
            q.partner_status = 1'($urandom);
            roll             = $urandom_range(99);
            idx              = -1;
            if (sb.partner_busy()) begin
                if (roll < 85) begin
                    q.req_type       = REQ_RESP;
                    q.partner_status = ($urandom_range(99) < 88) ? PSTAT_OK : ~PSTAT_OK;
                end else if (roll < 92) begin
                    q.req_type = REQ_ALLOC;
                end else if (roll < 97) begin
                    q.req_type = REQ_FREE;
                    idx        = sb.pick_used();
                end else begin
                    q.req_type = REQ_UNUSED;
                end
            end else begin
                filling   = counted < (target * 6) / 10;
                alloc_pct = filling ? 85 : 25;
                free_pct  = filling ? 5 : 60;
                if (roll < alloc_pct) begin
                    q.req_type = REQ_ALLOC;
                end else if (roll < alloc_pct + free_pct) begin
                    q.req_type = REQ_FREE;
                    idx        = sb.pick_used();
                end else begin
                    case ($urandom_range(2))
                        0:       q.req_type = REQ_FREE;
                        1:       q.req_type = REQ_RESP;
                        default: q.req_type = REQ_UNUSED;
                    endcase
                end
            end
            if (idx >= 0)
                q.free_addr = (32'(idx) << CHUNK_SHIFT_BITS) | ($urandom & LOW_MASK);
            if (q.req_type != REQ_UNUSED && !(q.req_type == REQ_RESP && !sb.partner_busy()))
                counted++;
            send(q);
        end
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(1280);
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        for (int w = 0; w < 20000 && sb.due_results.size() != 0; w++)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (sb.due_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, sb.due_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/bca_pkg.sv
design/bca_if.sv
design/bca_map.sv
design/bitmap_chunk_allocator.sv
dv/tb_top.sv
